>>> hw/rtl/erwl_pkg.sv
// Shared types, codes and default sizes of the epoch replay window ledger.
package erwl_pkg;

	localparam int WINDOW_WORDS_DEF = 16;
	localparam int MAX_REJECTS_DEF  = 64;
	localparam int MAX_PARTIALS_DEF = 64;

	localparam logic [31:0] MAX_SEQ_JUMP_RST = 32'd65536;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_RECORD = 1'b1;

	localparam logic [1:0] KIND_APPLIED  = 2'd0;
	localparam logic [1:0] KIND_PARTIAL  = 2'd1;
	localparam logic [1:0] KIND_REJECTED = 2'd2;
	localparam logic [1:0] KIND_REFUSED  = 2'd3;

	typedef enum logic [2:0] {
		ST_INVALID, ST_STALE, ST_BEHIND, ST_UNSEEN,
		ST_AHEAD, ST_JUMP, ST_APPLIED, ST_REJECTED
	} seq_state_t;

	typedef enum logic [2:0] {W_HOLD, W_CLR, W_WSH, W_BSH, W_SET} win_op_t;

	typedef struct packed {
		win_op_t    op;
		logic [5:0] bsh;
		logic [5:0] bit_sel;
		logic       set_app;
	} win_ctl_t;

	typedef enum logic [2:0] {L_HOLD, L_CLEAR, L_PRUNE, L_EVICT, L_INSERT, L_SCLR, L_SCAN} lst_op_t;

	typedef struct packed {
		lst_op_t     op;
		logic [63:0] key;
	} lst_ctl_t;

	typedef struct packed {
		logic        shl;
		logic        ins;
		logic        sclr;
		logic        scan;
		logic [63:0] key;
	} lcell_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLASS, S_NEWEP, S_PREP, S_SHW, S_SHB,
		S_PRUNE, S_MARK, S_INS, S_SCLR, S_SCAN, S_DONE
	} ctl_state_t;

endpackage

>>> hw/rtl/erwl_chan_if.sv
// Valid/ready channel interfaces for ledger operations and their results.
interface erwl_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] epoch;
	logic [63:0] seq;
	logic [1:0]  kind;
	logic [31:0] reason;

	modport source (output valid, command, epoch, seq, kind, reason, input ready);
	modport sink (input valid, command, epoch, seq, kind, reason, output ready);
endinterface

interface erwl_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  seq_state;
	logic        accepted;
	logic [31:0] reason_found;
	logic        is_partial;

	modport source (output valid, seq_state, accepted, reason_found, is_partial, input ready);
	modport sink (input valid, seq_state, accepted, reason_found, is_partial, output ready);
endinterface

>>> hw/rtl/erwl_win_cell.sv
// One 64-bit word of the seen and applied window bitmaps.
module erwl_win_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  erwl_pkg::win_ctl_t ctl,
	input  logic               sel,
	input  logic [63:0]        nxt_seen,
	input  logic [63:0]        nxt_app,
	output logic [63:0]        seen,
	output logic [63:0]        app
);
	import erwl_pkg::*;

	logic [63:0]  seen_q;
	logic [63:0]  app_q;
	logic [127:0] seen_cat;
	logic [127:0] app_cat;

	assign seen_cat = {nxt_seen, seen_q} >> ctl.bsh;
	assign app_cat  = {nxt_app, app_q} >> ctl.bsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			app_q  <= '0;
		end else begin
			case (ctl.op)
				W_CLR: begin
					seen_q <= '0;
					app_q  <= '0;
				end
				W_WSH: begin
					seen_q <= nxt_seen;
					app_q  <= nxt_app;
				end
				W_BSH: begin
					seen_q <= seen_cat[63:0];
					app_q  <= app_cat[63:0];
				end
				W_SET: begin
					if (sel) begin
						seen_q[ctl.bit_sel] <= 1'b1;
						if (ctl.set_app) app_q[ctl.bit_sel] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign seen = seen_q;
	assign app  = app_q;
endmodule

>>> hw/rtl/erwl_lst_cell.sv
// One entry of a sorted list, with its link in the lookup chain.
module erwl_lst_cell #(
	parameter int PAY_W = 32
) (
	input  logic                 clk,
	input  erwl_pkg::lcell_ctl_t ctl,
	input  logic [PAY_W-1:0]     pay_in,
	input  logic                 valid,
	input  logic                 is_first,
	input  logic                 gt_left,
	input  logic [63:0]          seq_left,
	input  logic [PAY_W-1:0]     pay_left,
	input  logic [63:0]          seq_right,
	input  logic [PAY_W-1:0]     pay_right,
	input  logic [PAY_W-1:0]     res_left,
	output logic [63:0]          seq,
	output logic [PAY_W-1:0]     pay,
	output logic                 gt,
	output logic [PAY_W-1:0]     res
);
	import erwl_pkg::*;

	logic [63:0]      seq_q;
	logic [PAY_W-1:0] pay_q;
	logic [PAY_W-1:0] res_q;

	assign gt = !valid || (seq_q > ctl.key);

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			seq_q <= seq_right;
			pay_q <= pay_right;
		end else if (ctl.ins && gt) begin
			if (is_first || !gt_left) begin
				seq_q <= ctl.key;
				pay_q <= pay_in;
			end else begin
				seq_q <= seq_left;
				pay_q <= pay_left;
			end
		end
		if (ctl.sclr) begin
			res_q <= '0;
		end else if (ctl.scan) begin
			if (res_left != '0) res_q <= res_left;
			else if (valid && seq_q == ctl.key) res_q <= pay_q;
			else res_q <= '0;
		end
	end

	assign seq = seq_q;
	assign pay = pay_q;
	assign res = res_q;
endmodule

>>> hw/rtl/erwl_list.sv
// Sorted list built as a chain of entry cells, with prune, evict, insert and lookup.
module erwl_list #(
	parameter int N     = erwl_pkg::MAX_REJECTS_DEF,
	parameter int PAY_W = 32,
	localparam int CW   = $clog2(N + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  erwl_pkg::lst_ctl_t ctl,
	input  logic [PAY_W-1:0]   pay,
	output logic [PAY_W-1:0]   found,
	output logic               prune_done,
	output logic [CW-1:0]      count
);
	import erwl_pkg::*;

	logic [CW-1:0]    count_q;
	logic             skip_q;
	logic             full;
	logic             prune_ok;
	lcell_ctl_t       cctl;
	logic [63:0]      seq_w [N];
	logic [PAY_W-1:0] pay_w [N];
	logic [PAY_W-1:0] res_w [N];
	logic             gt_w  [N];

	assign full     = count_q == CW'(N);
	assign prune_ok = (count_q != '0) && (seq_w[0] <= ctl.key);

	always_comb begin
		cctl.key  = ctl.key;
		cctl.shl  = ((ctl.op == L_PRUNE) && prune_ok) ||
		            ((ctl.op == L_EVICT) && full && !gt_w[0]);
		cctl.ins  = (ctl.op == L_INSERT) && !skip_q;
		cctl.sclr = ctl.op == L_SCLR;
		cctl.scan = ctl.op == L_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			skip_q  <= 1'b0;
		end else begin
			if (ctl.op == L_EVICT) skip_q <= full && gt_w[0];
			if (ctl.op == L_CLEAR) count_q <= '0;
			else if (cctl.shl) count_q <= count_q - 1'b1;
			else if (cctl.ins) count_q <= count_q + 1'b1;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic             gl;
		logic [63:0]      sl;
		logic [PAY_W-1:0] pl;
		logic [63:0]      sr;
		logic [PAY_W-1:0] pr;
		logic [PAY_W-1:0] rl;
		if (i == 0) begin : g_first
			assign gl = 1'b0;
			assign sl = '0;
			assign pl = '0;
			assign rl = '0;
		end else begin : g_mid
			assign gl = gt_w[i-1];
			assign sl = seq_w[i-1];
			assign pl = pay_w[i-1];
			assign rl = res_w[i-1];
		end
		if (i == N - 1) begin : g_last
			assign sr = '0;
			assign pr = '0;
		end else begin : g_inner
			assign sr = seq_w[i+1];
			assign pr = pay_w[i+1];
		end
		erwl_lst_cell #(.PAY_W(PAY_W)) u_cell (
			.clk      (clk),
			.ctl      (cctl),
			.pay_in   (pay),
			.valid    (CW'(i) < count_q),
			.is_first (i == 0),
			.gt_left  (gl),
			.seq_left (sl),
			.pay_left (pl),
			.seq_right(sr),
			.pay_right(pr),
			.res_left (rl),
			.seq      (seq_w[i]),
			.pay      (pay_w[i]),
			.gt       (gt_w[i]),
			.res      (res_w[i])
		);
	end

	assign found      = res_w[N-1];
	assign prune_done = !prune_ok;
	assign count      = count_q;
endmodule

>>> hw/rtl/epoch_replay_window_ledger.sv
// Top level of the epoch replay window ledger: control sequencer, window cells and lists.
// The block keeps an anti-replay ledger for one stream. Operations arrive on in_ch as
// transfers carrying command, epoch, seq, kind and reason; a query only classifies and
// reports what is stored, a record classifies and, if accepted, updates the window and
// the rejection and partial lists. Each operation yields exactly one transfer on out_ch
// with seq_state, accepted, reason_found and is_partial.
// max_seq_jump is written through cfg_we and cfg_wdata; the user must write it only while
// the block is idle; the block itself does not enforce this. One operation is in flight
// at a time. A query is paced by the lookup result travelling down the list cell chains,
// the longer of which has max(MAX_REJECTS, MAX_PARTIALS) cells. An accepted record opens
// a newer epoch if its epoch is newer, prepares the slide, and then marks and inserts. A
// slide shifts the window cells by words and then by bits, or clears them if the jump
// spans the whole window, and then prunes both lists in parallel up to the new watermark.
// The result sits in an output register, so the next operation is taken while it waits.
// If out_ch stalls with a result still held, a finished operation waits in its last
// step until the register frees. Asynchronous reset empties the window and both lists,
// clears epoch, watermark and highest sequence, and sets max_seq_jump to 65536; no
// clearing pass is needed.
module epoch_replay_window_ledger #(
	parameter int WINDOW_WORDS = erwl_pkg::WINDOW_WORDS_DEF,
	parameter int MAX_REJECTS  = erwl_pkg::MAX_REJECTS_DEF,
	parameter int MAX_PARTIALS = erwl_pkg::MAX_PARTIALS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	erwl_in_if.sink     in_ch,
	erwl_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import erwl_pkg::*;

	localparam logic [63:0] WIN_BITS  = 64'(WINDOW_WORDS * 64);
	localparam logic [63:0] LOW_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF - WIN_BITS;
	localparam int WW_W   = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
	localparam int SCAN_N = (MAX_REJECTS > MAX_PARTIALS) ? MAX_REJECTS : MAX_PARTIALS;
	localparam int SC_W   = $clog2(SCAN_N + 1);
	localparam int RC_W   = $clog2(MAX_REJECTS + 1);
	localparam int PC_W   = $clog2(MAX_PARTIALS + 1);

	ctl_state_t  state_q, state_d;
	logic        cmd_q;
	logic [63:0] epoch_q;
	logic [63:0] seq_q;
	logic [1:0]  kind_q;
	logic [31:0] reason_q;
	logic [31:0] jump_q;
	logic [63:0] cur_epoch_q;
	logic [63:0] low_q;
	logic [63:0] high_q;
	seq_state_t  st_q, st_c;
	logic        acc_q;
	logic [WW_W-1:0] ws_q;
	logic [5:0]  bs_q;
	logic [SC_W-1:0] scan_cnt_q;

	logic        out_valid_q;
	logic [2:0]  out_state_q;
	logic        out_acc_q;
	logic [31:0] out_reason_q;
	logic        out_part_q;
	logic        out_free;

	logic [64:0] jump_sum;
	logic [63:0] top_win;
	logic [63:0] idx;
	logic [63:0] shift;
	logic [WW_W-1:0] widx;
	logic        rd_seen, rd_app;
	logic        take;
	logic        rej_do, par_do;

	win_ctl_t    win_ctl;
	lst_ctl_t    rej_ctl, par_ctl;
	logic [31:0] rej_found;
	logic [0:0]  par_found;
	logic        rej_pdone, par_pdone;
	logic [RC_W-1:0] rej_cnt;
	logic [PC_W-1:0] par_cnt;

	logic [63:0] seen_w [WINDOW_WORDS];
	logic [63:0] app_w  [WINDOW_WORDS];

	assign jump_sum = {1'b0, high_q} + {33'b0, jump_q};
	assign top_win  = low_q + WIN_BITS;
	assign idx      = seq_q - low_q - 64'd1;
	assign shift    = seq_q - top_win;
	assign widx     = idx[6 +: WW_W];
	assign rd_seen  = seen_w[widx][idx[5:0]];
	assign rd_app   = app_w[widx][idx[5:0]];
	assign rej_do   = (kind_q == KIND_REJECTED) && (reason_q != '0);
	assign par_do   = kind_q == KIND_PARTIAL;
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		if (seq_q == '0 || epoch_q == '0) st_c = ST_INVALID;
		else if (epoch_q < cur_epoch_q) st_c = ST_STALE;
		else if (epoch_q > cur_epoch_q) st_c = (seq_q <= {32'b0, jump_q}) ? ST_UNSEEN : ST_JUMP;
		else if (low_q > LOW_LIMIT) st_c = ST_INVALID;
		else if (seq_q <= low_q) st_c = ST_BEHIND;
		else if (!jump_sum[64] && seq_q > jump_sum[63:0]) st_c = ST_JUMP;
		else if (seq_q > top_win) st_c = ST_AHEAD;
		else if (!rd_seen) st_c = ST_UNSEEN;
		else st_c = rd_app ? ST_APPLIED : ST_REJECTED;
	end

	assign take = (cmd_q == CMD_RECORD) && (kind_q != KIND_REFUSED) &&
	              (st_c == ST_UNSEEN || st_c == ST_AHEAD);

	always_comb begin
		state_d         = state_q;
		win_ctl.op      = W_HOLD;
		win_ctl.bsh     = bs_q;
		win_ctl.bit_sel = idx[5:0];
		win_ctl.set_app = (kind_q == KIND_APPLIED) || (kind_q == KIND_PARTIAL);
		rej_ctl.op      = L_HOLD;
		rej_ctl.key     = (state_q == S_PRUNE) ? low_q : seq_q;
		par_ctl.op      = L_HOLD;
		par_ctl.key     = rej_ctl.key;
		in_ch.ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = S_CLASS;
			end
			S_CLASS: begin
				if (!take) state_d = S_SCLR;
				else if (epoch_q > cur_epoch_q) state_d = S_NEWEP;
				else state_d = S_PREP;
			end
			S_NEWEP: begin
				win_ctl.op = W_CLR;
				rej_ctl.op = L_CLEAR;
				par_ctl.op = L_CLEAR;
				state_d    = S_PREP;
			end
			S_PREP: begin
				if (seq_q > top_win) begin
					if (shift >= WIN_BITS) begin
						win_ctl.op = W_CLR;
						state_d    = S_PRUNE;
					end else if (shift[6 +: WW_W] == '0) begin
						state_d = S_SHB;
					end else begin
						state_d = S_SHW;
					end
				end else begin
					state_d = S_MARK;
				end
			end
			S_SHW: begin
				win_ctl.op = W_WSH;
				if (ws_q == WW_W'(1)) state_d = S_SHB;
			end
			S_SHB: begin
				win_ctl.op = W_BSH;
				state_d    = S_PRUNE;
			end
			S_PRUNE: begin
				rej_ctl.op = L_PRUNE;
				par_ctl.op = L_PRUNE;
				if (rej_pdone && par_pdone) state_d = S_MARK;
			end
			S_MARK: begin
				win_ctl.op = W_SET;
				if (rej_do) rej_ctl.op = L_EVICT;
				if (par_do) par_ctl.op = L_EVICT;
				state_d = S_INS;
			end
			S_INS: begin
				if (rej_do) rej_ctl.op = L_INSERT;
				if (par_do) par_ctl.op = L_INSERT;
				state_d = S_SCLR;
			end
			S_SCLR: begin
				rej_ctl.op = L_SCLR;
				par_ctl.op = L_SCLR;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				rej_ctl.op = L_SCAN;
				par_ctl.op = L_SCAN;
				if (scan_cnt_q == SC_W'(SCAN_N - 1)) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q    <= in_ch.command;
			epoch_q  <= in_ch.epoch;
			seq_q    <= in_ch.seq;
			kind_q   <= in_ch.kind;
			reason_q <= in_ch.reason;
		end
		if (state_q == S_CLASS) st_q <= st_c;
		if (state_q == S_PREP) begin
			ws_q <= shift[6 +: WW_W];
			bs_q <= shift[5:0];
		end else if (state_q == S_SHW) begin
			ws_q <= ws_q - 1'b1;
		end
		if (state_q == S_SCLR) scan_cnt_q <= '0;
		else if (state_q == S_SCAN) scan_cnt_q <= scan_cnt_q + 1'b1;
		if (state_q == S_DONE && out_free) begin
			out_state_q  <= st_q;
			out_acc_q    <= acc_q;
			out_reason_q <= rej_found;
			out_part_q   <= par_found[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q      <= MAX_SEQ_JUMP_RST;
			cur_epoch_q <= '0;
			low_q       <= '0;
			high_q      <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) jump_q <= cfg_wdata;
			if (state_q == S_CLASS) acc_q <= take;
			if (state_q == S_NEWEP) begin
				cur_epoch_q <= epoch_q;
				low_q       <= '0;
				high_q      <= '0;
			end
			if (state_q == S_PREP && seq_q > top_win) low_q <= seq_q - WIN_BITS;
			if (state_q == S_MARK && seq_q > high_q) high_q <= seq_q;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < WINDOW_WORDS; i++) begin : g_win
		logic [63:0] ns, na;
		if (i == WINDOW_WORDS - 1) begin : g_last
			assign ns = '0;
			assign na = '0;
		end else begin : g_inner
			assign ns = seen_w[i+1];
			assign na = app_w[i+1];
		end
		erwl_win_cell u_wcell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (win_ctl),
			.sel     (widx == WW_W'(i)),
			.nxt_seen(ns),
			.nxt_app (na),
			.seen    (seen_w[i]),
			.app     (app_w[i])
		);
	end

	erwl_list #(.N(MAX_REJECTS), .PAY_W(32)) u_rej (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rej_ctl),
		.pay       (reason_q),
		.found     (rej_found),
		.prune_done(rej_pdone),
		.count     (rej_cnt)
	);

	erwl_list #(.N(MAX_PARTIALS), .PAY_W(1)) u_par (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (par_ctl),
		.pay       (1'b1),
		.found     (par_found),
		.prune_done(par_pdone),
		.count     (par_cnt)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.seq_state    = out_state_q;
	assign out_ch.accepted     = out_acc_q;
	assign out_ch.reason_found = out_reason_q;
	assign out_ch.is_partial   = out_part_q;

	a_acc_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.accepted |->
		(out_ch.seq_state == ST_UNSEEN || out_ch.seq_state == ST_AHEAD))
		else $error("accepted result with a refused classification");

	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rej_cnt <= RC_W'(MAX_REJECTS)) && (par_cnt <= PC_W'(MAX_PARTIALS)))
		else $error("list count beyond its capacity");

	a_low_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) != S_NEWEP |-> low_q >= $past(low_q))
		else $error("watermark moved back within an epoch");

	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> $stable(low_q) && $stable(cur_epoch_q))
		else $error("ledger state changed during lookup");
endmodule
